/* design/wtsp_pkg.sv */
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants for the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

    localparam int NUM_REGS   = 7;
    localparam int ADDR_W     = 3;
    localparam int CFG_W      = 64;
    localparam int NUM_LANES  = 2;   // divider lanes: screen x, screen y
    localparam int NUM_W      = 51;  // |clip| * 8 * size < 2^50
    localparam int DEN_W      = 32;
    localparam int DIV_STAGES = NUM_W;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_COEFF_11_21 = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COEFF_31_41 = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COEFF_12_22 = 3'd2;
    localparam logic [ADDR_W-1:0] REG_COEFF_32_42 = 3'd3;
    localparam logic [ADDR_W-1:0] REG_COEFF_14_24 = 3'd4;
    localparam logic [ADDR_W-1:0] REG_COEFF_34_44 = 3'd5;
    localparam logic [ADDR_W-1:0] REG_SCREEN_SIZE = 3'd6;

    localparam logic [CFG_W-1:0] RST_COEFF_11_21 = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_COEFF_31_41 = 64'h0;
    localparam logic [CFG_W-1:0] RST_COEFF_12_22 = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_COEFF_32_42 = 64'h0;
    localparam logic [CFG_W-1:0] RST_COEFF_14_24 = 64'h0;
    localparam logic [CFG_W-1:0] RST_COEFF_34_44 = 64'h0001_0000_0000_0000;
    localparam logic [31:0]      RST_SCREEN_SIZE = 32'd70780800;

    // |w| / 25600 = ((|w| >> 10) * ceil(2^26 / 25)) >> 26, exact for |w| <= 2^31
    localparam logic [21:0] DIST_RECIP = 22'd2684355;

    // lane order
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;

    // clip term order
    localparam int CLIP_W = 0;
    localparam int CLIP_X = 1;
    localparam int CLIP_Y = 2;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] t;
    } col_t;

    // sideband carried alongside the divider
    typedef struct packed {
        logic signed [31:0] w;
        logic [16:0]        dist_mag;
        logic               neg_x;
        logic               neg_y;
        logic               zero;
    } side_t;

endpackage

/* design/wtsp_dot.sv */
// ----------------------------------------------------------------------------
// wtsp_dot
// Two-stage dot product: registered products, then floored sum and saturation.
// ----------------------------------------------------------------------------
module wtsp_dot
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  wtsp_pkg::col_t     col [3],
    output logic               out_valid,
    output logic signed [31:0] clip [3]
);

    logic               v1_reg;
    logic               v2_reg;
    logic signed [63:0] prod_reg [3][3];
    logic signed [31:0] tr_reg   [3];
    logic signed [31:0] clip_reg [3];
    logic signed [49:0] sum      [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j][0] <= col[j].a * pos_x;
                prod_reg[j][1] <= col[j].b * pos_y;
                prod_reg[j][2] <= col[j].c * pos_z;
                tr_reg[j]      <= col[j].t;
            end
        end
    end

    // products are Q.24, floor to Q.8; translation Q16.16 floors to Q.8
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = 50'(prod_reg[j][0] >>> 16) + 50'(prod_reg[j][1] >>> 16)
                   + 50'(prod_reg[j][2] >>> 16) + 50'(tr_reg[j] >>> 8);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (sum[j] > 50'sd2147483647)
                    clip_reg[j] <= 32'sh7fff_ffff;
                else if (sum[j] < -50'sd2147483648)
                    clip_reg[j] <= 32'sh8000_0000;
                else
                    clip_reg[j] <= sum[j][31:0];
            end
        end
    end

    assign out_valid = v2_reg;
    assign clip      = clip_reg;

endmodule

/* design/wtsp_scale.sv */
// ----------------------------------------------------------------------------
// wtsp_scale
// Sign/magnitude split and scaling of clip terms by 8 * screen size.
// ----------------------------------------------------------------------------
module wtsp_scale
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [31:0]                  clip [3],
    input  logic [31:0]                         screen_size,
    output logic                                out_valid,
    output logic [wtsp_pkg::NUM_W-1:0]          num  [wtsp_pkg::NUM_LANES],
    output logic [wtsp_pkg::DEN_W-1:0]          den  [wtsp_pkg::NUM_LANES],
    output wtsp_pkg::side_t                     side
);

    logic                         v_reg;
    logic [wtsp_pkg::NUM_W-1:0]   num_reg [wtsp_pkg::NUM_LANES];
    logic [wtsp_pkg::DEN_W-1:0]   den_reg [wtsp_pkg::NUM_LANES];
    wtsp_pkg::side_t              side_reg;
    logic [31:0]                  mag_w;
    logic [31:0]                  mag_x;
    logic [31:0]                  mag_y;
    logic [18:0]                  scl_x;
    logic [18:0]                  scl_y;
    logic [43:0]                  dist_prod;

    assign mag_w = clip[wtsp_pkg::CLIP_W][31] ? 32'(-clip[wtsp_pkg::CLIP_W])
                                              : clip[wtsp_pkg::CLIP_W];
    assign mag_x = clip[wtsp_pkg::CLIP_X][31] ? 32'(-clip[wtsp_pkg::CLIP_X])
                                              : clip[wtsp_pkg::CLIP_X];
    assign mag_y = clip[wtsp_pkg::CLIP_Y][31] ? 32'(-clip[wtsp_pkg::CLIP_Y])
                                              : clip[wtsp_pkg::CLIP_Y];
    assign scl_x = {screen_size[15:0], 3'b000};
    assign scl_y = {screen_size[31:16], 3'b000};

    // distance by reciprocal: 22 x 22 bit product, quotient fits 17 bits
    assign dist_prod = 44'(mag_w[31:10]) * 44'(wtsp_pkg::DIST_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[wtsp_pkg::LANE_X] <= 51'(mag_x) * 51'(scl_x);
            num_reg[wtsp_pkg::LANE_Y] <= 51'(mag_y) * 51'(scl_y);
            den_reg[wtsp_pkg::LANE_X] <= mag_w;
            den_reg[wtsp_pkg::LANE_Y] <= mag_w;
            side_reg.w        <= clip[wtsp_pkg::CLIP_W];
            side_reg.dist_mag <= dist_prod[42:26];
            side_reg.neg_x    <= clip[wtsp_pkg::CLIP_X][31] ^ clip[wtsp_pkg::CLIP_W][31];
            side_reg.neg_y    <= clip[wtsp_pkg::CLIP_Y][31] ^ clip[wtsp_pkg::CLIP_W][31];
            side_reg.zero     <= (clip[wtsp_pkg::CLIP_W] == 32'sd0);
        end
    end

    assign out_valid = v_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

/* design/wtsp_div.sv */
// ----------------------------------------------------------------------------
// wtsp_div
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module wtsp_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [wtsp_pkg::NUM_W-1:0]   num  [wtsp_pkg::NUM_LANES],
    input  logic [wtsp_pkg::DEN_W-1:0]   den  [wtsp_pkg::NUM_LANES],
    input  wtsp_pkg::side_t              side_in,
    output logic                         out_valid,
    output logic [wtsp_pkg::NUM_W-1:0]   quot [wtsp_pkg::NUM_LANES],
    output wtsp_pkg::side_t              side_out
);

    localparam int S = wtsp_pkg::DIV_STAGES;
    localparam int L = wtsp_pkg::NUM_LANES;
    localparam int N = wtsp_pkg::NUM_W;
    localparam int D = wtsp_pkg::DEN_W;

    logic             v_reg    [S];
    logic [D-1:0]     rem_reg  [S][L];
    logic [N-1:0]     numr_reg [S][L];
    logic [D-1:0]     den_reg  [S][L];
    logic [N-1:0]     quo_reg  [S][L];
    wtsp_pkg::side_t  side_reg [S];

    genvar k;
    generate
        for (k = 0; k < S; k++)
        begin : g_stage
            logic             v_in;
            logic [D-1:0]     r_in   [L];
            logic [N-1:0]     n_in   [L];
            logic [D-1:0]     d_in   [L];
            logic [N-1:0]     q_in   [L];
            wtsp_pkg::side_t  s_in;
            logic [D:0]       trial  [L];
            logic             ge     [L];

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    v_in = in_valid;
                    s_in = side_in;
                    for (int l = 0; l < L; l++)
                    begin
                        r_in[l] = '0;
                        n_in[l] = num[l];
                        d_in[l] = den[l];
                        q_in[l] = '0;
                    end
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    v_in = v_reg[k-1];
                    s_in = side_reg[k-1];
                    for (int l = 0; l < L; l++)
                    begin
                        r_in[l] = rem_reg[k-1][l];
                        n_in[l] = numr_reg[k-1][l];
                        d_in[l] = den_reg[k-1][l];
                        q_in[l] = quo_reg[k-1][l];
                    end
                end
            end

            always_comb
            begin
                for (int l = 0; l < L; l++)
                begin
                    trial[l] = {r_in[l], n_in[l][N-1]};
                    ge[l]    = (trial[l] >= {1'b0, d_in[l]});
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= s_in;
                    for (int l = 0; l < L; l++)
                    begin
                        rem_reg[k][l]  <= ge[l] ? D'(trial[l] - {1'b0, d_in[l]})
                                                : trial[l][D-1:0];
                        numr_reg[k][l] <= {n_in[l][N-2:0], 1'b0};
                        den_reg[k][l]  <= d_in[l];
                        quo_reg[k][l]  <= {q_in[l][N-2:0], ge[l]};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[S-1];
    assign quot      = quo_reg[S-1];
    assign side_out  = side_reg[S-1];

endmodule

/* design/world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Fixed-point perspective projection of world points to screen coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one world point per beat (pos_x, pos_y, pos_z,
//   signed Q23.8). Output stream m_axis returns one beat per point: screen x/y
//   in 1/16 pixel, clip depth w (Q23.8), w/100 in whole units, and a zero-depth
//   flag on tuser. When w is zero the screen coordinates read zero.
//   The matrix and screen size sit in seven registers on the cfg port; write
//   them only while no beat is in flight.
// Timing:
//   Stages: product stage, sum/saturate stage, scale stage, 51 stages of
//   restoring division (one quotient bit each), output register. The 51-bit
//   quotient width sets the depth; one beat per cycle unless the output is held.
// Reset:
//   Registers return to identity columns and a 1920 x 1080 screen; every
//   pipeline valid bit clears, so no stray beat comes out.
// Stall:
//   The whole pipeline advances on one enable, high when the output register
//   is empty or being taken. A held output freezes every stage in place and
//   drops s_axis_tready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module world_to_screen_projection
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [wtsp_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [wtsp_pkg::CFG_W-1:0]     cfg_data,
    // input points
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [95:0]                    s_axis_tdata,  // pos_x, pos_y, pos_z
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [111:0]                   m_axis_tdata,  // screen_x, screen_y, depth,
                                                          // distance_units, zero pad
    output logic [0:0]                     m_axis_tuser   // depth_zero
);

    logic [wtsp_pkg::CFG_W-1:0] coeff_reg [6];
    logic [31:0]                screen_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg[wtsp_pkg::REG_COEFF_11_21] <= wtsp_pkg::RST_COEFF_11_21;
            coeff_reg[wtsp_pkg::REG_COEFF_31_41] <= wtsp_pkg::RST_COEFF_31_41;
            coeff_reg[wtsp_pkg::REG_COEFF_12_22] <= wtsp_pkg::RST_COEFF_12_22;
            coeff_reg[wtsp_pkg::REG_COEFF_32_42] <= wtsp_pkg::RST_COEFF_32_42;
            coeff_reg[wtsp_pkg::REG_COEFF_14_24] <= wtsp_pkg::RST_COEFF_14_24;
            coeff_reg[wtsp_pkg::REG_COEFF_34_44] <= wtsp_pkg::RST_COEFF_34_44;
            screen_size_reg                      <= wtsp_pkg::RST_SCREEN_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wtsp_pkg::REG_COEFF_11_21,
                wtsp_pkg::REG_COEFF_31_41,
                wtsp_pkg::REG_COEFF_12_22,
                wtsp_pkg::REG_COEFF_32_42,
                wtsp_pkg::REG_COEFF_14_24,
                wtsp_pkg::REG_COEFF_34_44: coeff_reg[cfg_addr] <= cfg_data;
                wtsp_pkg::REG_SCREEN_SIZE: screen_size_reg <= cfg_data[31:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // matrix columns: w from column 4, x from column 1, y from column 2
    wtsp_pkg::col_t col [3];

    always_comb
    begin
        col[wtsp_pkg::CLIP_W].a = coeff_reg[wtsp_pkg::REG_COEFF_14_24][31:0];
        col[wtsp_pkg::CLIP_W].b = coeff_reg[wtsp_pkg::REG_COEFF_14_24][63:32];
        col[wtsp_pkg::CLIP_W].c = coeff_reg[wtsp_pkg::REG_COEFF_34_44][31:0];
        col[wtsp_pkg::CLIP_W].t = coeff_reg[wtsp_pkg::REG_COEFF_34_44][63:32];
        col[wtsp_pkg::CLIP_X].a = coeff_reg[wtsp_pkg::REG_COEFF_11_21][31:0];
        col[wtsp_pkg::CLIP_X].b = coeff_reg[wtsp_pkg::REG_COEFF_11_21][63:32];
        col[wtsp_pkg::CLIP_X].c = coeff_reg[wtsp_pkg::REG_COEFF_31_41][31:0];
        col[wtsp_pkg::CLIP_X].t = coeff_reg[wtsp_pkg::REG_COEFF_31_41][63:32];
        col[wtsp_pkg::CLIP_Y].a = coeff_reg[wtsp_pkg::REG_COEFF_12_22][31:0];
        col[wtsp_pkg::CLIP_Y].b = coeff_reg[wtsp_pkg::REG_COEFF_12_22][63:32];
        col[wtsp_pkg::CLIP_Y].c = coeff_reg[wtsp_pkg::REG_COEFF_32_42][31:0];
        col[wtsp_pkg::CLIP_Y].t = coeff_reg[wtsp_pkg::REG_COEFF_32_42][63:32];
    end

    // single pipeline enable: move when the output slot is free or drained
    logic out_valid_reg;
    logic en;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic               dot_valid;
    logic signed [31:0] clip [3];

    wtsp_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .pos_x     (s_axis_tdata[31:0]),
        .pos_y     (s_axis_tdata[63:32]),
        .pos_z     (s_axis_tdata[95:64]),
        .col       (col),
        .out_valid (dot_valid),
        .clip      (clip)
    );

    logic                         scl_valid;
    logic [wtsp_pkg::NUM_W-1:0]   scl_num [wtsp_pkg::NUM_LANES];
    logic [wtsp_pkg::DEN_W-1:0]   scl_den [wtsp_pkg::NUM_LANES];
    wtsp_pkg::side_t              scl_side;

    wtsp_scale u_scale
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (dot_valid),
        .clip        (clip),
        .screen_size (screen_size_reg),
        .out_valid   (scl_valid),
        .num         (scl_num),
        .den         (scl_den),
        .side        (scl_side)
    );

    logic                         div_valid;
    logic [wtsp_pkg::NUM_W-1:0]   quot [wtsp_pkg::NUM_LANES];
    wtsp_pkg::side_t              div_side;

    wtsp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (scl_valid),
        .num       (scl_num),
        .den       (scl_den),
        .side_in   (scl_side),
        .out_valid (div_valid),
        .quot      (quot),
        .side_out  (div_side)
    );

    // final: apply signs, offset from screen centre, saturate to 28 bits, zero on zero depth
    logic signed [52:0] q_x;
    logic signed [52:0] q_y;
    logic signed [52:0] sum_x;
    logic signed [52:0] sum_y;
    logic signed [27:0] sx_next;
    logic signed [27:0] sy_next;
    logic signed [17:0] dist_next;
    logic [16:0]        q_d;

    always_comb
    begin
        q_x   = div_side.neg_x ? -$signed({2'b00, quot[wtsp_pkg::LANE_X]})
                               :  $signed({2'b00, quot[wtsp_pkg::LANE_X]});
        q_y   = div_side.neg_y ? -$signed({2'b00, quot[wtsp_pkg::LANE_Y]})
                               :  $signed({2'b00, quot[wtsp_pkg::LANE_Y]});
        sum_x = $signed({34'd0, screen_size_reg[15:0], 3'b000}) + q_x;
        sum_y = $signed({34'd0, screen_size_reg[31:16], 3'b000}) - q_y;

        if (div_side.zero)
            sx_next = '0;
        else if (sum_x > 53'sd134217727)
            sx_next = 28'sh7ff_ffff;
        else if (sum_x < -53'sd134217728)
            sx_next = 28'sh800_0000;
        else
            sx_next = sum_x[27:0];

        if (div_side.zero)
            sy_next = '0;
        else if (sum_y > 53'sd134217727)
            sy_next = 28'sh7ff_ffff;
        else if (sum_y < -53'sd134217728)
            sy_next = 28'sh800_0000;
        else
            sy_next = sum_y[27:0];

        // |w| / 25600 from the scale stage, fits in 17 bits
        q_d       = div_side.dist_mag;
        dist_next = div_side.w[31] ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});
    end

    logic signed [27:0] sx_reg;
    logic signed [27:0] sy_reg;
    logic signed [31:0] depth_reg;
    logic signed [17:0] dist_reg;
    logic               zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            depth_reg <= div_side.w;
            dist_reg  <= dist_next;
            zero_reg  <= div_side.zero;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, dist_reg, depth_reg, sy_reg, sx_reg};
    assign m_axis_tuser  = zero_reg;

    // zero flag matches the reported depth
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[87:56] == 32'd0)))
        else $error("depth_zero disagrees with depth");

    // zero depth forces screen coordinates to zero
    a_zero_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[55:0] == 56'd0))
        else $error("screen coordinates not cleared on zero depth");

    // distance carries the sign of depth
    a_dist_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[105:88] != 18'd0))
        |-> (m_axis_tdata[105] == m_axis_tdata[87]))
        else $error("distance sign differs from depth sign");

    // input only backs off behind a held result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // a stalled result stays in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("held result changed");

endmodule

/* bench/wtsp_checker.sv */
// ----------------------------------------------------------------------------
// wtsp_checker
// Watches the point and result streams and the register port, predicts each
// projected point and compares it field by field with the result beats.
// ----------------------------------------------------------------------------
module wtsp_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wtsp_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [wtsp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [111:0]                  m_axis_tdata,
    input  logic [0:0]                    m_axis_tuser,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic signed [27:0] sx;
        logic signed [27:0] sy;
        logic signed [31:0] depth;
        logic signed [17:0] dist_units;
        logic               zero;
    } proj_t;

    logic [wtsp_pkg::CFG_W-1:0] regs [wtsp_pkg::NUM_REGS];
    proj_t                      proj_q[$];

    function automatic logic signed [63:0] sat64(logic signed [63:0] v,
                                                 logic signed [63:0] lo,
                                                 logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floored dot product of one matrix column plus translation, Q23.8
    function automatic logic signed [63:0] clip_sum(logic [wtsp_pkg::CFG_W-1:0] ab,
                                                    logic [wtsp_pkg::CFG_W-1:0] ct,
                                                    logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
        logic signed [63:0] s;
        s = ((64'(signed'(ab[31:0])) * 64'(x)) >>> 16)
          + ((64'(signed'(ab[63:32])) * 64'(y)) >>> 16)
          + ((64'(signed'(ct[31:0])) * 64'(z)) >>> 16)
          + (64'(signed'(ct[63:32])) >>> 8);
        return sat64(s, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // trunc(num * m / den) toward zero
    function automatic logic signed [63:0] scaled_quot(logic signed [63:0] num,
                                                       logic signed [63:0] den,
                                                       logic [63:0] m);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = (a * m) / b;
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic proj_t project(logic [95:0] pt);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [63:0] w;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic [63:0]        wx8;
        logic [63:0]        hy8;
        proj_t              r;
        x = pt[31:0];
        y = pt[63:32];
        z = pt[95:64];
        w  = clip_sum(regs[wtsp_pkg::REG_COEFF_14_24], regs[wtsp_pkg::REG_COEFF_34_44],
                      x, y, z);
        cx = clip_sum(regs[wtsp_pkg::REG_COEFF_11_21], regs[wtsp_pkg::REG_COEFF_31_41],
                      x, y, z);
        cy = clip_sum(regs[wtsp_pkg::REG_COEFF_12_22], regs[wtsp_pkg::REG_COEFF_32_42],
                      x, y, z);
        wx8 = 64'(regs[wtsp_pkg::REG_SCREEN_SIZE][15:0]) * 8;
        hy8 = 64'(regs[wtsp_pkg::REG_SCREEN_SIZE][31:16]) * 8;
        r.depth      = w[31:0];
        r.dist_units = 18'(w / 25600);
        r.zero       = (w == 0);
        r.sx = '0;
        r.sy = '0;
        if (!r.zero)
        begin
            r.sx = 28'(sat64($signed(wx8) + scaled_quot(cx, w, wx8),
                             -64'sd134217728, 64'sd134217727));
            r.sy = 28'(sat64($signed(hy8) - scaled_quot(cy, w, hy8),
                             -64'sd134217728, 64'sd134217727));
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        proj_t got;
        proj_t want;
        if (!rst_n)
        begin
            regs[wtsp_pkg::REG_COEFF_11_21] = wtsp_pkg::RST_COEFF_11_21;
            regs[wtsp_pkg::REG_COEFF_31_41] = wtsp_pkg::RST_COEFF_31_41;
            regs[wtsp_pkg::REG_COEFF_12_22] = wtsp_pkg::RST_COEFF_12_22;
            regs[wtsp_pkg::REG_COEFF_32_42] = wtsp_pkg::RST_COEFF_32_42;
            regs[wtsp_pkg::REG_COEFF_14_24] = wtsp_pkg::RST_COEFF_14_24;
            regs[wtsp_pkg::REG_COEFF_34_44] = wtsp_pkg::RST_COEFF_34_44;
            regs[wtsp_pkg::REG_SCREEN_SIZE] = 64'(wtsp_pkg::RST_SCREEN_SIZE);
            proj_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sx         = m_axis_tdata[27:0];
                got.sy         = m_axis_tdata[55:28];
                got.depth      = m_axis_tdata[87:56];
                got.dist_units = m_axis_tdata[105:88];
                got.zero       = m_axis_tuser[0];
                if (proj_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %h", got);
                end
                else
                begin
                    want = proj_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch (exp/act): sx %0d/%0d sy %0d/%0d ",
                                      "depth %0d/%0d dist %0d/%0d zero %0b/%0b"},
                                     want.sx, got.sx, want.sy, got.sy,
                                     want.depth, got.depth,
                                     want.dist_units, got.dist_units,
                                     want.zero, got.zero);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                proj_q.push_back(project(s_axis_tdata));
            if (cfg_we && cfg_addr < wtsp_pkg::NUM_REGS)
                regs[cfg_addr] = (cfg_addr == wtsp_pkg::REG_SCREEN_SIZE)
                               ? {32'd0, cfg_data[31:0]} : cfg_data;
            pending = proj_q.size();
        end
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives world points through the projection block over several matrix and
// screen settings, with random gaps on both streams and one long output hold.
// ----------------------------------------------------------------------------
module tb;

    localparam int  LATENCY     = 55;
    localparam int  RANDOM_PTS  = 1300;
    localparam int  PHASES      = 5;
    localparam int  CYCLE_LIMIT = 400000;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [wtsp_pkg::ADDR_W-1:0]  cfg_addr;
    logic [wtsp_pkg::CFG_W-1:0]   cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [95:0]                  s_axis_tdata;   // pos_x, pos_y, pos_z
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [111:0]                 m_axis_tdata;   // screen_x, screen_y, depth,
                                                  // distance_units, pad
    logic [0:0]                   m_axis_tuser;   // depth_zero
    int                           fail_count;
    int                           pending;
    int                           cycles;
    bit                           calm;           // no idling in the final stretch
    bit                           hold_req;       // ask the sink for one long hold-off

    world_to_screen_projection dut (.*);

    wtsp_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // sink: random ready bursts; one long hold while the source keeps pushing
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                m_axis_tready = 1'b0;
                for (n = 0; n < 300; n++)
                    @(negedge clk);
                held = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready = 1'b0;
                n = $urandom_range(1, 14);
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            if (!calm)
            begin
                n = $urandom_range(1, 30);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic reg_write(logic [wtsp_pkg::ADDR_W-1:0] idx,
                             logic [wtsp_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // offer one point at the falling edge, hold until taken
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid = 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7fff_fffc | $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    initial
    begin
        int ph;
        int i;
        int n;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed points at reset settings: identity columns, w = 1.0
        send_point(32'h0, 32'h0, 32'h0);                    // origin
        send_point(32'h100, 32'h100, 32'h0);                // nonzero clip x and y
        send_point(32'h100, 32'h200, 32'h100);
        send_point(32'hffff_ff00, 32'hffff_fe00, 32'h100);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1);    // screen saturation
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(32'h0, 32'h0, 32'd25599);                // z does not reach w here
        send_point(32'h0, 32'h0, 32'd25600);
        send_point(32'h0, 32'h0, -32'sd25600);
        send_point(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
        drain();

        // extreme coefficients, saturating sums, tiny and huge screens
        reg_write(wtsp_pkg::REG_COEFF_11_21, 64'h7fff_ffff_8000_0000);
        reg_write(wtsp_pkg::REG_COEFF_31_41, 64'h8000_0000_7fff_ffff);
        reg_write(wtsp_pkg::REG_COEFF_12_22, 64'h8000_0000_7fff_ffff);
        reg_write(wtsp_pkg::REG_COEFF_32_42, 64'h7fff_ffff_8000_0000);
        reg_write(wtsp_pkg::REG_COEFF_14_24, 64'hffff_ffff_ffff_ffff);
        reg_write(wtsp_pkg::REG_COEFF_34_44, 64'h7fff_ffff_0000_0001);
        reg_write(wtsp_pkg::REG_SCREEN_SIZE, 64'hdead_beef_ffff_ffff);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h1, 32'hffff_ffff, 32'h1);
        drain();
        reg_write(wtsp_pkg::REG_SCREEN_SIZE, 64'h0);
        send_point(32'h100, 32'h100, 32'h100);
        drain();

        // random phases: new matrix and screen each time, the last at reset-like values
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
            begin
                reg_write(wtsp_pkg::REG_COEFF_11_21, wtsp_pkg::RST_COEFF_11_21);
                reg_write(wtsp_pkg::REG_COEFF_31_41, wtsp_pkg::RST_COEFF_31_41);
                reg_write(wtsp_pkg::REG_COEFF_12_22, wtsp_pkg::RST_COEFF_12_22);
                reg_write(wtsp_pkg::REG_COEFF_32_42, wtsp_pkg::RST_COEFF_32_42);
                reg_write(wtsp_pkg::REG_COEFF_14_24, wtsp_pkg::RST_COEFF_14_24);
                reg_write(wtsp_pkg::REG_COEFF_34_44, wtsp_pkg::RST_COEFF_34_44);
                reg_write(wtsp_pkg::REG_SCREEN_SIZE, 64'(wtsp_pkg::RST_SCREEN_SIZE));
            end
            else
            begin
                reg_write(wtsp_pkg::REG_COEFF_11_21, {rand_coeff(), rand_coeff()});
                reg_write(wtsp_pkg::REG_COEFF_31_41, {rand_coeff(), rand_coeff()});
                reg_write(wtsp_pkg::REG_COEFF_12_22, {rand_coeff(), rand_coeff()});
                reg_write(wtsp_pkg::REG_COEFF_32_42, {rand_coeff(), rand_coeff()});
                reg_write(wtsp_pkg::REG_COEFF_14_24, {rand_coeff(), rand_coeff()});
                reg_write(wtsp_pkg::REG_COEFF_34_44, {rand_coeff(), rand_coeff()});
                reg_write(wtsp_pkg::REG_SCREEN_SIZE, {$urandom(), $urandom()});
            end
            n = RANDOM_PTS / PHASES;
            for (i = 0; i < n; i++)
            begin
                if (ph == 1 && i == 20)
                    hold_req = 1'b1;
                if (ph == PHASES - 1 && i == n / 2)
                    calm = 1'b1;
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
